FILE: sv/epve_pkg.sv
// Shared types and constants for the encoder position/velocity estimator.
// No dependencies; every other file of the block refers to it by scoped names.
package epve_pkg;

    localparam int CNT_W      = 48;   // raw encoder count
    localparam int DELTA_W    = 49;   // count difference
    localparam int SUM_W      = 52;   // low-speed accumulator
    localparam int OPND_W     = 52;   // multiplier operand (covers delta and sum)
    localparam int GAIN_W     = 32;   // Q16.16 gains and threshold
    localparam int RES_W      = 64;   // saturated results
    localparam int SAMP_W     = 4;    // low-speed sample counter
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int LANES      = 3;

    localparam int AVERAGE_SAMPLES_DEF = 11;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN = 3'd5;

    localparam logic [GAIN_W-1:0] UNIT_GAIN_RST = 32'd65536;
    localparam logic [GAIN_W-1:0] FAST_GAIN_RST = 32'd65536;
    localparam logic [GAIN_W-1:0] SLOW_GAIN_RST = 32'd6554;

    // what the back end does with the velocity estimate
    localparam logic [1:0] VEL_HOLD  = 2'd0;
    localparam logic [1:0] VEL_LOAD  = 2'd1;
    localparam logic [1:0] VEL_CLEAR = 2'd2;

    // multiplier lanes
    localparam int LANE_INC = 0;
    localparam int LANE_POS = 1;
    localparam int LANE_VEL = 2;

    typedef struct packed {
        logic                     reverse;
        logic signed [CNT_W-1:0]  origin;
        logic [GAIN_W-1:0]        unit_gain;
        logic [GAIN_W-1:0]        threshold;
        logic [GAIN_W-1:0]        fast_gain;
        logic [GAIN_W-1:0]        slow_gain;
    } cfg_t;

    // classified sample passed from front to back
    typedef struct packed {
        logic                      zero;
        logic                      low;
        logic signed [DELTA_W-1:0] delta;
        logic signed [DELTA_W-1:0] diff;
    } entry_t;

endpackage

FILE: sv/epve_queue.sv
// Small FIFO of classified samples between front and back end.
// Depends on epve_pkg for the entry type.
module epve_queue #(
    parameter int DEPTH = epve_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  epve_pkg::entry_t wr_data,
    output logic            full,
    input  logic            pop,
    output epve_pkg::entry_t rd_data,
    output logic            empty
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    epve_pkg::entry_t slot_reg [DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == COUNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

FILE: sv/epve_front.sv
// Front end: takes sample beats, applies direction, forms delta and offset
// from origin, classifies fast/low speed and pushes into the queue. Uses epve_pkg.
module epve_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_zero,
    input  logic signed [epve_pkg::CNT_W-1:0] in_count,
    input  epve_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output epve_pkg::entry_t              q_entry
);

    localparam logic signed [epve_pkg::CNT_W-1:0] CNT_MIN =
        {1'b1, {(epve_pkg::CNT_W-1){1'b0}}};
    localparam logic signed [epve_pkg::CNT_W-1:0] CNT_MAX =
        {1'b0, {(epve_pkg::CNT_W-1){1'b1}}};

    logic                              f1_valid_reg;
    logic                              f1_zero_reg;
    logic signed [epve_pkg::CNT_W-1:0] f1_count_reg;
    logic signed [epve_pkg::CNT_W-1:0] last_reg, last_next;

    logic signed [epve_pkg::CNT_W-1:0]   dir_count;
    logic signed [epve_pkg::DELTA_W-1:0] delta;
    logic signed [epve_pkg::DELTA_W-1:0] diff;
    logic                                low;
    logic                                accept;

    assign in_ready = !f1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = f1_valid_reg && !q_full;

    // negate for reversed mounting; the most negative count saturates
    always_comb
    begin
        dir_count = in_count;
        if (cfg.reverse)
        begin
            dir_count = (in_count == CNT_MIN) ? CNT_MAX : -in_count;
        end
    end

    always_comb
    begin
        delta = epve_pkg::DELTA_W'(f1_count_reg) - epve_pkg::DELTA_W'(last_reg);
        diff  = epve_pkg::DELTA_W'(f1_count_reg) - epve_pkg::DELTA_W'(cfg.origin);
        if (f1_zero_reg)
        begin
            delta = '0;
            diff  = '0;
        end
        // low speed: negative, or delta * 65536 below the threshold
        low = delta[epve_pkg::DELTA_W-1]
            || ((delta[epve_pkg::DELTA_W-1:16] == '0)
                && ({delta[15:0], 16'h0000} < cfg.threshold));
        q_entry.zero  = f1_zero_reg;
        q_entry.low   = low;
        q_entry.delta = delta;
        q_entry.diff  = diff;

        last_next = last_reg;
        if (q_push)
        begin
            last_next = f1_zero_reg ? '0 : f1_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            last_reg     <= '0;
        end
        else
        begin
            last_reg <= last_next;
            if (accept)
            begin
                f1_valid_reg <= 1'b1;
            end
            else if (q_push)
            begin
                f1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_zero_reg  <= in_zero;
            f1_count_reg <= dir_count;
        end
    end

    a_zero_clears_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && f1_zero_reg) |=> (last_reg == '0))
        else $error("zero command did not clear last count");

endmodule

FILE: sv/epve_back.sv
// Back end: low-speed accumulation, three saturating gain multiplies split
// into partial products, velocity state and the output register. Uses epve_pkg.
module epve_back #(
    parameter int AVERAGE_SAMPLES = epve_pkg::AVERAGE_SAMPLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  epve_pkg::cfg_t                     cfg,
    input  logic                               q_empty,
    input  epve_pkg::entry_t                   q_entry,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [epve_pkg::DELTA_W-1:0] out_delta,
    output logic signed [epve_pkg::RES_W-1:0]   out_increment,
    output logic signed [epve_pkg::RES_W-1:0]   out_position,
    output logic signed [epve_pkg::RES_W-1:0]   out_velocity
);

    localparam int OPND_W = epve_pkg::OPND_W;
    localparam int GAIN_W = epve_pkg::GAIN_W;
    localparam int RES_W  = epve_pkg::RES_W;
    localparam int SUM_W  = epve_pkg::SUM_W;
    localparam int SAMP_W = epve_pkg::SAMP_W;
    localparam int LANES  = epve_pkg::LANES;
    localparam int LO_W   = 32;
    localparam int HI_W   = OPND_W - LO_W;
    localparam int PROD_W = OPND_W + GAIN_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // low-speed state
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SAMP_W-1:0]       cnt_reg, cnt_next;

    // stage 1: operands
    logic                             v1_reg;
    logic [1:0]                       kind1_reg;
    logic signed [epve_pkg::DELTA_W-1:0] delta1_reg;
    logic signed [OPND_W-1:0]         opnd1_reg [LANES];
    logic [GAIN_W-1:0]                gain1_reg [LANES];
    // stage 2: sign and magnitude
    logic                             v2_reg;
    logic [1:0]                       kind2_reg;
    logic signed [epve_pkg::DELTA_W-1:0] delta2_reg;
    logic                             neg2_reg  [LANES];
    logic [OPND_W-1:0]                mag2_reg  [LANES];
    logic [GAIN_W-1:0]                gain2_reg [LANES];
    // stage 3: partial products
    logic                             v3_reg;
    logic [1:0]                       kind3_reg;
    logic signed [epve_pkg::DELTA_W-1:0] delta3_reg;
    logic                             neg3_reg  [LANES];
    logic [LO_W+GAIN_W-1:0]           lo3_reg   [LANES];
    logic [HI_W+GAIN_W-1:0]           hi3_reg   [LANES];
    // output register
    logic                             out_valid_reg;
    logic signed [epve_pkg::DELTA_W-1:0] delta_out_reg;
    logic signed [RES_W-1:0]          inc_reg, pos_reg, vel_reg;

    logic                             adv;
    logic [1:0]                       kind1;
    logic signed [OPND_W-1:0]         vel_opnd;
    logic [GAIN_W-1:0]                vel_gain;
    logic [SAMP_W-1:0]                cnt_inc;
    logic signed [SUM_W:0]            sum_add;
    logic signed [SUM_W-1:0]          sum_sat;
    logic signed [RES_W-1:0]          res   [LANES];
    logic [PROD_W-1:0]                prod  [LANES];

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign out_valid     = out_valid_reg;
    assign out_delta     = delta_out_reg;
    assign out_increment = inc_reg;
    assign out_position  = pos_reg;
    assign out_velocity  = vel_reg;

    // low-speed accumulation and velocity operand selection
    always_comb
    begin
        cnt_inc = cnt_reg + 1'b1;
        sum_add = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(q_entry.delta);
        if (sum_add[SUM_W] != sum_add[SUM_W-1])
        begin
            sum_sat = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_add[SUM_W-1:0];
        end

        sum_next = sum_reg;
        cnt_next = cnt_reg;
        kind1    = epve_pkg::VEL_HOLD;
        vel_opnd = '0;
        vel_gain = cfg.fast_gain;
        if (q_entry.zero)
        begin
            kind1 = epve_pkg::VEL_CLEAR;
        end
        else if (!q_entry.low)
        begin
            kind1    = epve_pkg::VEL_LOAD;
            vel_opnd = OPND_W'(q_entry.delta);
            sum_next = '0;
            cnt_next = '0;
        end
        else if (cnt_inc >= SAMP_W'(AVERAGE_SAMPLES))
        begin
            kind1    = epve_pkg::VEL_LOAD;
            vel_opnd = OPND_W'(sum_sat);
            vel_gain = cfg.slow_gain;
            sum_next = '0;
            cnt_next = '0;
        end
        else
        begin
            sum_next = sum_sat;
            cnt_next = cnt_inc;
        end
    end

    // recombine partial products and saturate to 64 bits
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = PROD_W'(lo3_reg[i]) + {hi3_reg[i], {LO_W{1'b0}}};
            if (neg3_reg[i])
            begin
                if ((prod[i][PROD_W-1:RES_W] != '0)
                    || (prod[i][RES_W-1] && (prod[i][RES_W-2:0] != '0)))
                begin
                    res[i] = RES_MIN;
                end
                else
                begin
                    res[i] = -$signed(prod[i][RES_W-1:0]);
                end
            end
            else
            begin
                if (prod[i][PROD_W-1:RES_W-1] != '0)
                begin
                    res[i] = RES_MAX;
                end
                else
                begin
                    res[i] = $signed(prod[i][RES_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            vel_reg       <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= q_pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
            if (q_pop)
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
            if (v3_reg)
            begin
                case (kind3_reg)
                    epve_pkg::VEL_LOAD:  vel_reg <= res[epve_pkg::LANE_VEL];
                    epve_pkg::VEL_CLEAR: vel_reg <= '0;
                    default:             vel_reg <= vel_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg  <= kind1;
            delta1_reg <= q_entry.delta;
            opnd1_reg[epve_pkg::LANE_INC] <= OPND_W'(q_entry.delta);
            opnd1_reg[epve_pkg::LANE_POS] <= OPND_W'(q_entry.diff);
            opnd1_reg[epve_pkg::LANE_VEL] <= vel_opnd;
            gain1_reg[epve_pkg::LANE_INC] <= cfg.unit_gain;
            gain1_reg[epve_pkg::LANE_POS] <= cfg.unit_gain;
            gain1_reg[epve_pkg::LANE_VEL] <= vel_gain;

            kind2_reg  <= kind1_reg;
            delta2_reg <= delta1_reg;
            kind3_reg  <= kind2_reg;
            delta3_reg <= delta2_reg;
            for (int i = 0; i < LANES; i++)
            begin
                neg2_reg[i]  <= opnd1_reg[i][OPND_W-1];
                mag2_reg[i]  <= opnd1_reg[i][OPND_W-1] ? OPND_W'(-opnd1_reg[i])
                                                       : OPND_W'(opnd1_reg[i]);
                gain2_reg[i] <= gain1_reg[i];

                neg3_reg[i]  <= neg2_reg[i];
                lo3_reg[i]   <= mag2_reg[i][LO_W-1:0] * gain2_reg[i];
                hi3_reg[i]   <= mag2_reg[i][OPND_W-1:LO_W] * gain2_reg[i];
            end

            delta_out_reg <= delta3_reg;
            inc_reg       <= res[epve_pkg::LANE_INC];
            pos_reg       <= res[epve_pkg::LANE_POS];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < SAMP_W'(AVERAGE_SAMPLES))
        else $error("low-speed sample count reached its limit without reload");

    a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("low-speed sum nonzero with no samples");

    a_clear_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v3_reg && (kind3_reg == epve_pkg::VEL_CLEAR)) |=> (vel_reg == '0))
        else $error("zero command did not clear velocity");

endmodule

FILE: sv/encoder_position_velocity_estimator.sv
// Encoder position/velocity estimator: an accepted s_ beat passes the front
// register, the queue and the four-stage multiply pipeline to its result on
// m_; one beat per cycle sustained while m_tready does not hold the output.
// Reset (rst_n low, asynchronous) loads the register defaults and clears
// last count, low-speed sum and count, and the velocity estimate.
// Depends on epve_pkg, epve_front, epve_queue and epve_back.
module encoder_position_velocity_estimator #(
    parameter int AVERAGE_SAMPLES = epve_pkg::AVERAGE_SAMPLES_DEF,
    parameter int QUEUE_DEPTH     = epve_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // encoder_count[47:0]
    input  logic                                s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // delta_counts[48:0], increment[112:49], position[176:113], velocity[240:177]
    output logic [247:0]                        m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [epve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [epve_pkg::CFG_DATA_W-1:0]     cfg_data
);

    epve_pkg::cfg_t   cfg_reg;
    epve_pkg::entry_t push_entry;
    epve_pkg::entry_t pop_entry;

    logic q_push, q_pop, q_full, q_empty;

    logic signed [epve_pkg::DELTA_W-1:0] delta;
    logic signed [epve_pkg::RES_W-1:0]   increment;
    logic signed [epve_pkg::RES_W-1:0]   position;
    logic signed [epve_pkg::RES_W-1:0]   velocity;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse   <= 1'b0;
            cfg_reg.origin    <= '0;
            cfg_reg.unit_gain <= epve_pkg::UNIT_GAIN_RST;
            cfg_reg.threshold <= '0;
            cfg_reg.fast_gain <= epve_pkg::FAST_GAIN_RST;
            cfg_reg.slow_gain <= epve_pkg::SLOW_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                epve_pkg::REG_REVERSE:   cfg_reg.reverse   <= cfg_data[0];
                epve_pkg::REG_ORIGIN:    cfg_reg.origin    <= cfg_data[47:0];
                epve_pkg::REG_UNIT_GAIN: cfg_reg.unit_gain <= cfg_data[31:0];
                epve_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_data[31:0];
                epve_pkg::REG_FAST_GAIN: cfg_reg.fast_gain <= cfg_data[31:0];
                epve_pkg::REG_SLOW_GAIN: cfg_reg.slow_gain <= cfg_data[31:0];
                default:                 cfg_reg           <= cfg_reg;
            endcase
        end
    end

    epve_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_zero  (s_tuser),
        .in_count ($signed(s_tdata)),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    epve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_entry),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (pop_entry),
        .empty   (q_empty)
    );

    epve_back #(
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_entry       (pop_entry),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_delta     (delta),
        .out_increment (increment),
        .out_position  (position),
        .out_velocity  (velocity)
    );

    assign m_tdata = {7'b0, velocity, position, increment, delta};

endmodule

FILE: tb/encoder_position_velocity_estimator_tb.sv
// Self-checking testbench for encoder_position_velocity_estimator: directed corner cases,
// then constrained-by-hand random sample streams under several idle and backpressure mixes.
// Depends on epve_pkg and the estimator RTL only.
`timescale 1ns / 100ps

module encoder_position_velocity_estimator_tb;

    localparam int AVERAGE_SAMPLES = epve_pkg::AVERAGE_SAMPLES_DEF;
    localparam int LATENCY         = 5;
    localparam int STALL_LIMIT     = 5000;
    localparam int RX_HOLD_CYCLES  = 300;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ZERO   = 1'b1;

    localparam logic [epve_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [epve_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [48:0] CNT_MOST_NEG = -49'sd140737488355328;
    localparam logic signed [48:0] CNT_MOST_POS = 49'sd140737488355327;
    localparam logic [47:0]        RAW_MOST_NEG = 48'h8000_0000_0000;
    localparam logic [47:0]        RAW_MOST_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [51:0] SUM_MOST_NEG = {1'b1, 51'd0};
    localparam logic signed [51:0] SUM_MOST_POS = {1'b0, {51{1'b1}}};
    localparam logic signed [63:0] RES_MOST_NEG = {1'b1, 63'd0};
    localparam logic signed [63:0] RES_MOST_POS = {1'b0, {63{1'b1}}};

    // same bit layout as m_tdata[240:0]
    typedef struct packed {
        logic signed [63:0] vel;
        logic signed [63:0] pos;
        logic signed [63:0] incr;
        logic signed [48:0] delta;
    } est_t;

    typedef struct packed {
        logic                    rev;
        logic signed [47:0]      origin;
        logic [31:0]             unit_gain;
        logic [31:0]             threshold;
        logic [31:0]             fast_gain;
        logic [31:0]             slow_gain;
    } settings_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [47:0]                     s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [247:0]                    m_tdata;
    logic                            cfg_wr_en;
    logic [epve_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [epve_pkg::CFG_DATA_W-1:0] cfg_data;

    // estimator state mirrored by the predictor
    settings_t          cfg_now;
    logic signed [48:0] est_last_count;
    logic [3:0]         est_slow_samples;
    logic signed [51:0] est_slow_sum;
    logic signed [63:0] est_velocity;

    est_t        pending_estimates[$];
    logic [47:0] last_raw;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_reqs = 0;
    int          errors = 0;
    int          quiet_cycles;

    encoder_position_velocity_estimator #(
        .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [63:0] mul_sat(input logic signed [51:0] a,
                                                   input logic [31:0] g);
        logic signed [84:0] p;
        p = a * $signed({1'b0, g});
        if (p[84:63] != {22{p[84]}})
            return p[84] ? RES_MOST_NEG : RES_MOST_POS;
        return p[63:0];
    endfunction

    function automatic est_t estimate_motion(input logic op, input logic [47:0] raw);
        est_t               r;
        logic signed [48:0] c;
        logic signed [48:0] delta;
        logic signed [48:0] rel;
        logic signed [52:0] acc;
        logic               low;
        r = '0;
        if (op == OP_ZERO)
        begin
            est_last_count = '0;
            est_velocity   = '0;
            return r;
        end
        c = $signed({raw[47], raw});
        if (cfg_now.rev)
            c = (c == CNT_MOST_NEG) ? CNT_MOST_POS : -c;
        delta = c - est_last_count;
        rel   = c - 49'(cfg_now.origin);
        est_last_count = c;
        r.delta = delta;
        r.incr  = mul_sat(52'(delta), cfg_now.unit_gain);
        r.pos   = mul_sat(52'(rel), cfg_now.unit_gain);

        if (delta < 0)
            low = 1'b1;
        else if (delta >= 49'sd65536)
            low = 1'b0;
        else
            low = {delta[15:0], 16'h0000} < cfg_now.threshold;

        if (low)
        begin
            est_slow_samples = est_slow_samples + 4'd1;
            acc = 53'(est_slow_sum) + 53'(delta);
            if (acc[52] != acc[51])
                est_slow_sum = acc[52] ? SUM_MOST_NEG : SUM_MOST_POS;
            else
                est_slow_sum = acc[51:0];
            if (est_slow_samples >= AVERAGE_SAMPLES)
            begin
                est_velocity     = mul_sat(est_slow_sum, cfg_now.slow_gain);
                est_slow_samples = '0;
                est_slow_sum     = '0;
            end
        end
        else
        begin
            est_velocity     = mul_sat(52'(delta), cfg_now.fast_gain);
            est_slow_samples = '0;
            est_slow_sum     = '0;
        end
        r.vel = est_velocity;
        return r;
    endfunction

    function automatic settings_t reset_settings();
        settings_t s;
        s.rev       = 1'b0;
        s.origin    = '0;
        s.unit_gain = epve_pkg::UNIT_GAIN_RST;
        s.threshold = '0;
        s.fast_gain = epve_pkg::FAST_GAIN_RST;
        s.slow_gain = epve_pkg::SLOW_GAIN_RST;
        return s;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(1, 255);
            4: return $urandom_range(1, 20) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic settings_t random_settings();
        settings_t   s;
        logic [47:0] r48;
        r48   = 48'({$urandom, $urandom});
        s.rev = 1'($urandom_range(1));
        case ($urandom_range(4))
            0: s.origin = '0;
            1: s.origin = RAW_MOST_NEG;
            2: s.origin = RAW_MOST_POS;
            3: s.origin = 48'(int'($urandom_range(0, 2000)) - 1000);
            default: s.origin = r48;
        endcase
        s.unit_gain = pick_gain();
        case ($urandom_range(3))
            0: s.threshold = '0;
            1: s.threshold = 32'hFFFF_FFFF;
            2: s.threshold = {16'($urandom_range(1, 40)), 16'($urandom)};
            default: s.threshold = $urandom;
        endcase
        s.fast_gain = pick_gain();
        s.slow_gain = pick_gain();
        return s;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_reqs != hold_served)
            begin
                hold_left   = RX_HOLD_CYCLES;
                hold_served = rx_hold_reqs;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        est_t want;
        est_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[240:0];
            if (pending_estimates.size() == 0)
            begin
                $display("%0t unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (got.delta !== want.delta)
                begin
                    $display("%0t delta_counts expected %0d got %0d", $time, want.delta,
                             got.delta);
                    errors++;
                end
                if (got.incr !== want.incr)
                begin
                    $display("%0t increment expected %0d got %0d", $time, want.incr, got.incr);
                    errors++;
                end
                if (got.pos !== want.pos)
                begin
                    $display("%0t position expected %0d got %0d", $time, want.pos, got.pos);
                    errors++;
                end
                if (got.vel !== want.vel)
                begin
                    $display("%0t velocity expected %0d got %0d", $time, want.vel, got.vel);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
                $display("[encoder_position_velocity_estimator] ERROR");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic op, input logic [47:0] cnt);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cnt;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_estimates.push_back(estimate_motion(op, cnt));
        last_raw = (op == OP_ZERO) ? '0 : cnt;
    endtask

    // hold the input until every result is back, then let the pipe settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_estimates.size() != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic apply_config(input settings_t s);
        logic [47:0] junk;
        wait_drain();
        junk = 48'({$urandom, $urandom});
        cfg_wr_en <= 1'b1;
        cfg_index <= epve_pkg::REG_REVERSE;
        cfg_data  <= {junk[47:1], s.rev};
        @(posedge clk);
        cfg_index <= epve_pkg::REG_ORIGIN;
        cfg_data  <= s.origin;
        @(posedge clk);
        cfg_index <= epve_pkg::REG_UNIT_GAIN;
        cfg_data  <= {junk[47:32], s.unit_gain};
        @(posedge clk);
        cfg_index <= epve_pkg::REG_THRESHOLD;
        cfg_data  <= {junk[31:16], s.threshold};
        @(posedge clk);
        cfg_index <= epve_pkg::REG_FAST_GAIN;
        cfg_data  <= {junk[15:0], s.fast_gain};
        @(posedge clk);
        cfg_index <= epve_pkg::REG_SLOW_GAIN;
        cfg_data  <= {~junk[47:32], s.slow_gain};
        @(posedge clk);
        // indexes past the last register must be dropped
        cfg_index <= REG_SPARE_LO;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_index <= REG_SPARE_HI;
        cfg_data  <= ~junk;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        cfg_now = s;
    endtask

    task automatic send_random_item();
        int          kind;
        int          span;
        int          step;
        logic [47:0] cnt;
        kind = $urandom_range(99);
        span = int'(cfg_now.threshold[31:16]);
        if (kind < 4)
            cnt = 48'({$urandom, $urandom});
        else if (kind < 12)
            cnt = 48'({$urandom, $urandom});
        else if (kind < 16)
        begin
            case ($urandom_range(3))
                0: cnt = RAW_MOST_NEG;
                1: cnt = RAW_MOST_POS;
                2: cnt = '0;
                default: cnt = '1;
            endcase
        end
        else
        begin
            // walk near the last count so the low-speed path gets exercised
            if (kind < 24)
                step = -int'($urandom_range(0, 1000));
            else
                step = int'($urandom_range(0, span + 6)) - 3;
            if (cfg_now.rev)
                step = -step;
            cnt = last_raw + 48'(step);
        end
        send_beat((kind < 4) ? OP_ZERO : OP_SAMPLE, cnt);
    endtask

    task automatic test_reset_defaults();
        send_beat(OP_SAMPLE, 48'd0);
        send_beat(OP_SAMPLE, 48'd100);
        send_beat(OP_SAMPLE, RAW_MOST_POS);
        send_beat(OP_SAMPLE, RAW_MOST_NEG);
        send_beat(OP_ZERO, 48'hA5A5_5A5A_F00F);
        send_beat(OP_SAMPLE, 48'd1);
        send_beat(OP_SAMPLE, '1);
    endtask

    task automatic test_extremes();
        settings_t s;
        s           = reset_settings();
        s.rev       = 1'b1;
        s.origin    = RAW_MOST_NEG;
        s.unit_gain = 32'hFFFF_FFFF;
        s.threshold = 32'hFFFF_FFFF;
        s.fast_gain = 32'hFFFF_FFFF;
        s.slow_gain = 32'hFFFF_FFFF;
        apply_config(s);
        // negating the most negative count saturates
        send_beat(OP_SAMPLE, RAW_MOST_NEG);
        send_beat(OP_SAMPLE, RAW_MOST_POS);
        send_beat(OP_ZERO, '1);
        send_beat(OP_SAMPLE, RAW_MOST_NEG);
        send_beat(OP_SAMPLE, 48'd0);
    endtask

    task automatic test_low_speed_average();
        settings_t   s;
        logic [47:0] cnt;
        s           = reset_settings();
        s.threshold = 32'h0005_0000;
        apply_config(s);
        send_beat(OP_ZERO, '0);
        send_beat(OP_SAMPLE, 48'd4);
        send_beat(OP_SAMPLE, 48'd8);
        send_beat(OP_SAMPLE, 48'd13);    // delta at threshold: fast path
        cnt = 48'd13;
        for (int i = 0; i < 12; i++)
        begin
            if (i == 5)
            begin
                // zero keeps the running sum and count
                send_beat(OP_ZERO, cnt);
                cnt = '0;
            end
            else
            begin
                cnt = (i == 8) ? cnt - 48'd3 : cnt + 48'd4;
                send_beat(OP_SAMPLE, cnt);
            end
        end
    endtask

    task automatic test_random_stream(input int n, input int tx_pct, input int rx_pct);
        apply_config(random_settings());
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n) send_random_item();
    endtask

    task automatic test_backpressure();
        apply_config(random_settings());
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_reqs = rx_hold_reqs + 1;
        repeat (40) send_random_item();
        wait_drain();
        repeat (10) send_random_item();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_SAMPLE;
        cfg_wr_en    = 1'b0;
        cfg_index    = epve_pkg::REG_REVERSE;
        cfg_data     = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        last_raw     = '0;
        cfg_now          = reset_settings();
        est_last_count   = '0;
        est_slow_samples = '0;
        est_slow_sum     = '0;
        est_velocity     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_low_speed_average();
        test_random_stream(300, 0, 0);
        test_random_stream(300, 88, 0);
        test_random_stream(300, 0, 88);
        test_random_stream(300, 28, 28);
        test_backpressure();

        wait_drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0)
            $display("[encoder_position_velocity_estimator] OK");
        else
            $display("[encoder_position_velocity_estimator] ERROR");
        $finish;
    end

endmodule
